>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the vector normalizer.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

>>> src/vn_pkg.sv
// Package of the vector normalizer: output format constants.
// Depends on nothing; used by the divider lanes and the top level.
package vn_pkg;
   localparam int UNIT_FRAC = 30;
   localparam int UNIT_BITS = 32;
   localparam int QUOT_BITS = UNIT_FRAC + 1;
endpackage

>>> src/vn_square.sv
// Magnitude and sum-of-squares stages of the vector normalizer.
// Depends on nothing outside this file.
module vn_square #(
   parameter int W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [W-1:0]     vec_x,
   input  logic signed [W-1:0]     vec_y,
   input  logic signed [W-1:0]     vec_z,
   output logic                    out_valid,
   output logic [2*W+1:0]          out_sum,
   output logic [2:0][W-1:0]       out_mag,
   output logic [2:0]              out_neg
);
   localparam int S = 2 * W + 2;

   logic [2:0][W-1:0] raw;
   logic [2:0][W-1:0] mag_in;
   logic [2:0][W-1:0] mag_ff;
   logic [2:0][W-1:0] mag2_ff;
   logic [2:0]        neg_ff;
   logic [2:0]        neg2_ff;
   logic              valid1_ff;
   logic              valid2_ff;
   logic [S-1:0]      sum_in;
   logic [S-1:0]      sum_ff;

   assign raw[0] = vec_x;
   assign raw[1] = vec_y;
   assign raw[2] = vec_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = raw[i][W-1] ? W'(-raw[i]) : raw[i];
      end
      sum_in = S'(mag_ff[0]) * S'(mag_ff[0]) + S'(mag_ff[1]) * S'(mag_ff[1])
             + S'(mag_ff[2]) * S'(mag_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      mag_ff <= mag_in;
      neg_ff <= {raw[2][W-1], raw[1][W-1], raw[0][W-1]};
      sum_ff <= sum_in;
      mag2_ff <= mag_ff;
      neg2_ff <= neg_ff;
   end

   assign out_valid = valid2_ff;
   assign out_sum   = sum_ff;
   assign out_mag   = mag2_ff;
   assign out_neg   = neg2_ff;
endmodule

>>> src/vn_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing outside this file.
module vn_sqrt #(
   parameter int W    = 32,
   parameter int SIDE = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*W+1:0]    in_sum,
   input  logic [SIDE-1:0]   in_side,
   output logic              out_valid,
   output logic [W-1:0]      out_root,
   output logic [SIDE-1:0]   out_side
);
   localparam int S = 2 * W + 2;

   logic [S-1:0]    rem_ff   [W+1];
   logic [W-1:0]    root_ff  [W+1];
   logic [SIDE-1:0] side_ff  [W+1];
   logic            valid_ff [W+1];

   assign rem_ff[0]   = in_sum;
   assign root_ff[0]  = '0;
   assign side_ff[0]  = in_side;
   assign valid_ff[0] = in_valid;

   for (genvar k = 0; k < W; k++) begin : g_stage
      localparam int B = W - 1 - k;
      logic [S-1:0] trial;
      logic         take;
      logic [S-1:0] rem_in;
      logic [W-1:0] root_in;

      always_comb begin
         trial   = (S'(root_ff[k]) << (B + 1)) | (S'(1) << (2 * B));
         take    = rem_ff[k] >= trial;
         rem_in  = take ? rem_ff[k] - trial : rem_ff[k];
         root_in = take ? (root_ff[k] | (W'(1) << B)) : root_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[W];
   assign out_root  = root_ff[W];
   assign out_side  = side_ff[W];
endmodule

>>> src/vn_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on vn_pkg for the quotient width.
module vn_div_lane
   import vn_pkg::*;
#(
   parameter int W    = 32,
   parameter int SIDE = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [W-1:0]         in_mag,
   input  logic [W-1:0]         in_len,
   input  logic [SIDE-1:0]      in_side,
   output logic                 out_valid,
   output logic [QUOT_BITS-1:0] out_quot,
   output logic [SIDE-1:0]      out_side
);
   logic [W-1:0]         rem_ff   [QUOT_BITS+1];
   logic [W-1:0]         len_ff   [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS+1];
   logic [SIDE-1:0]      side_ff  [QUOT_BITS+1];
   logic                 valid_ff [QUOT_BITS+1];

   assign rem_ff[0]   = in_mag;
   assign len_ff[0]   = in_len;
   assign quot_ff[0]  = '0;
   assign side_ff[0]  = in_side;
   assign valid_ff[0] = in_valid;

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      logic [W:0]           shifted;
      logic                 take;
      logic [W:0]           diff;
      logic [W-1:0]         rem_in;
      logic [QUOT_BITS-1:0] quot_in;

      always_comb begin
         // The first stage yields the integer bit and does not shift.
         shifted = (j == 0) ? {1'b0, rem_ff[j]} : {rem_ff[j], 1'b0};
         take    = shifted >= {1'b0, len_ff[j]};
         diff    = shifted - {1'b0, len_ff[j]};
         rem_in  = take ? diff[W-1:0] : shifted[W-1:0];
         quot_in = {quot_ff[j][QUOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_ff[j];
         end
         rem_ff[j+1]  <= rem_in;
         len_ff[j+1]  <= len_ff[j];
         quot_ff[j+1] <= quot_in;
         side_ff[j+1] <= side_ff[j];
      end
   end

   assign out_valid = valid_ff[QUOT_BITS];
   assign out_quot  = quot_ff[QUOT_BITS];
   assign out_side  = side_ff[QUOT_BITS];
endmodule

>>> src/vector3_normalize.sv
// Throughput: one item per cycle; busy is always low since every stage advances each cycle.
// The depth is set by the square root, one root bit per stage, and the
// dividers, one quotient bit per stage. Synchronous active-high reset
// clears all valid bits; no item is in flight after reset.
// Depends on vn_pkg, vn_square, vn_sqrt, vn_div_lane and assert_macros.svh.
`include "assert_macros.svh"

module vector3_normalize
   import vn_pkg::*;
#(
   // Width of each input component. The fraction position cancels in the
   // quotient, so the number of fraction bits does not change any result.
   parameter int COMPONENT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COMPONENT_BITS-1:0] req_vec_x,
   input  logic signed [COMPONENT_BITS-1:0] req_vec_y,
   input  logic signed [COMPONENT_BITS-1:0] req_vec_z,
   output logic                          rsp_valid,
   output logic signed [UNIT_BITS-1:0]   rsp_unit_x,
   output logic signed [UNIT_BITS-1:0]   rsp_unit_y,
   output logic signed [UNIT_BITS-1:0]   rsp_unit_z,
   output logic                          rsp_is_zero
);
   localparam int W    = COMPONENT_BITS;
   localparam int SIDE = 3 * W + 3;

   logic                 sq_valid;
   logic [2*W+1:0]       sq_sum;
   logic [2:0][W-1:0]    sq_mag;
   logic [2:0]           sq_neg;

   logic                 rt_valid;
   logic [W-1:0]         rt_root;
   logic [SIDE-1:0]      rt_side;
   logic [2:0][W-1:0]    rt_mag;
   logic [2:0]           rt_neg;
   logic                 rt_zero;

   logic [2:0]                  dv_valid;
   logic [2:0][QUOT_BITS-1:0]   dv_quot;
   logic [1:0]                  dv_side_x;
   logic                        dv_side_y;
   logic                        dv_side_z;
   logic [2:0]                  dv_neg;
   logic [2:0][UNIT_BITS-1:0]   unit_in;

   logic                        rsp_valid_ff;
   logic [2:0][UNIT_BITS-1:0]   unit_ff;
   logic                        zero_ff;

   // Every stage moves each cycle and the receiver cannot stall, so the
   // block is always ready for a new item.
   assign busy = 1'b0;

   vn_square #(.W(W)) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .vec_z     (req_vec_z),
      .out_valid (sq_valid),
      .out_sum   (sq_sum),
      .out_mag   (sq_mag),
      .out_neg   (sq_neg)
   );

   // Magnitudes and signs travel alongside the root computation.
   vn_sqrt #(.W(W), .SIDE(SIDE)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_sum    (sq_sum),
      .in_side   ({sq_neg, sq_mag}),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   assign rt_mag  = rt_side[3*W-1:0];
   assign rt_neg  = rt_side[SIDE-1:3*W];
   assign rt_zero = (rt_root == '0);

   // The x lane also carries the zero-length flag to the output.
   vn_div_lane #(.W(W), .SIDE(2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_mag    (rt_mag[0]),
      .in_len    (rt_root),
      .in_side   ({rt_zero, rt_neg[0]}),
      .out_valid (dv_valid[0]),
      .out_quot  (dv_quot[0]),
      .out_side  (dv_side_x)
   );

   vn_div_lane #(.W(W), .SIDE(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_mag    (rt_mag[1]),
      .in_len    (rt_root),
      .in_side   (rt_neg[1]),
      .out_valid (dv_valid[1]),
      .out_quot  (dv_quot[1]),
      .out_side  (dv_side_y)
   );

   vn_div_lane #(.W(W), .SIDE(1)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_mag    (rt_mag[2]),
      .in_len    (rt_root),
      .in_side   (rt_neg[2]),
      .out_valid (dv_valid[2]),
      .out_quot  (dv_quot[2]),
      .out_side  (dv_side_z)
   );

   assign dv_neg = {dv_side_z, dv_side_y, dv_side_x[0]};

   // Apply the sign after the division; a zero length forces zero output.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side_x[1]) begin
            unit_in[i] = '0;
         end else if (dv_neg[i]) begin
            unit_in[i] = -UNIT_BITS'(dv_quot[i]);
         end else begin
            unit_in[i] = UNIT_BITS'(dv_quot[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[0];
      end
      unit_ff <= unit_in;
      zero_ff <= dv_side_x[1];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_unit_x  = unit_ff[0];
   assign rsp_unit_y  = unit_ff[1];
   assign rsp_unit_z  = unit_ff[2];
   assign rsp_is_zero = zero_ff;

   // The three divider lanes run in lockstep.
   `ASSERT_IMPLIES(a_lanes_aligned, clock, reset, dv_valid[0],
      dv_valid[1] && dv_valid[2])
   // A zero-length item returns the zero vector.
   `ASSERT_IMPLIES(a_zero_vector, clock, reset, rsp_valid && rsp_is_zero,
      rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
   // The x unit component never exceeds one in magnitude.
   `ASSERT_IMPLIES(a_unit_range, clock, reset, rsp_valid,
      rsp_unit_x <= 32'sh4000_0000 && rsp_unit_x >= -32'sh4000_0000)
endmodule

>>> sim/tb.sv
// Self-checking testbench for vector3_normalize: start/busy command input,
// rsp_valid strobed results, predicted with a bit-exact fixed-point normalizer.
// Depends on vn_pkg and the vector3_normalize RTL.
`timescale 1ns / 1ps

module tb
   import vn_pkg::*;
();

   localparam int COMP_BITS = 32;
   localparam int LATENCY = COMP_BITS + 34;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] x;
      logic signed [COMP_BITS-1:0] y;
      logic signed [COMP_BITS-1:0] z;
   } vector_t;

   typedef struct packed {
      logic signed [UNIT_BITS-1:0] ux;
      logic signed [UNIT_BITS-1:0] uy;
      logic signed [UNIT_BITS-1:0] uz;
      logic                        zero;
   } unit_vec_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COMP_BITS-1:0] req_vec_x = '0;
   logic signed [COMP_BITS-1:0] req_vec_y = '0;
   logic signed [COMP_BITS-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic signed [UNIT_BITS-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_is_zero;

   vector_t   pending_vectors[$];
   unit_vec_t expected_units[$];
   int        error_count = 0;
   int        quiet_cycles = 0;
   bit        stimulus_done = 1'b0;
   bit        calm_stretch = 1'b0;

   vector3_normalize #(.COMPONENT_BITS(COMP_BITS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_is_zero(rsp_is_zero)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Bit-exact normalizer: the sum of squares fits in 66 bits, the root in 33.
   function automatic unit_vec_t normalize_vector(vector_t v);
      logic [COMP_BITS:0] mag[3];
      logic               neg[3];
      logic [2*COMP_BITS+3:0] sum_sq;
      logic [COMP_BITS+1:0]   root, trial;
      logic [COMP_BITS+UNIT_FRAC+1:0] quot;
      logic [UNIT_BITS-1:0]  unit[3];
      unit_vec_t res;
      logic signed [COMP_BITS-1:0] comp[3];
      comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = comp[i][COMP_BITS-1];
         // One extra bit keeps the most negative value's magnitude exact.
         mag[i] = neg[i] ? -{comp[i][COMP_BITS-1], comp[i]} : {1'b0, comp[i]};
         sum_sq += mag[i] * mag[i];
      end
      root = '0;
      for (int b = COMP_BITS + 1; b >= 0; b--) begin
         trial = root | ({{(COMP_BITS+1){1'b0}}, 1'b1} << b);
         if ((2*COMP_BITS+4)'(trial) * (2*COMP_BITS+4)'(trial) <= sum_sq) root = trial;
      end
      if (root == 0) begin
         res = '{ux: '0, uy: '0, uz: '0, zero: 1'b1};
         return res;
      end
      for (int i = 0; i < 3; i++) begin
         // Magnitude never exceeds the root, so the quotient is at most 2^30.
         quot = ((COMP_BITS+UNIT_FRAC+2)'(mag[i]) << UNIT_FRAC) / root;
         unit[i] = neg[i] ? -quot[UNIT_BITS-1:0] : quot[UNIT_BITS-1:0];
      end
      res = '{ux: unit[0], uy: unit[1], uz: unit[2], zero: 1'b0};
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [COMP_BITS-1:0] random_component();
      // Mix full-range words with short ones so that the axes differ in scale.
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $signed($urandom_range(0, 65535)) - 32768;
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return '0;
         default: return $urandom() >>> $urandom_range(0, 31);
      endcase
   endfunction

   // Driver: each cycle it either idles or offers the next pending item.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            // The previous item went in on this edge.
            void'(pending_vectors.pop_front());
         end
         if (start && busy) begin
            // Hold the offered item until the block takes it.
         end else if (pending_vectors.size() > 0
                      && (calm_stretch || $urandom_range(0, 99) >= 34)) begin
            vector_t v;
            v = pending_vectors[0];
            start     <= 1'b1;
            req_vec_x <= v.x;
            req_vec_y <= v.y;
            req_vec_z <= v.z;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Prediction happens when the item is accepted, then checking on strobe.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            expected_units.push_back(normalize_vector('{x: req_vec_x, y: req_vec_y,
                                                        z: req_vec_z}));
         end
         if (rsp_valid) begin
            if (expected_units.size() == 0) begin
               report_mismatch("unexpected result", rsp_unit_x, 32'h0);
            end else begin
               unit_vec_t want;
               want = expected_units.pop_front();
               if (rsp_unit_x !== want.ux) report_mismatch("unit_x", rsp_unit_x, want.ux);
               if (rsp_unit_y !== want.uy) report_mismatch("unit_y", rsp_unit_y, want.uy);
               if (rsp_unit_z !== want.uz) report_mismatch("unit_z", rsp_unit_z, want.uz);
               if (rsp_is_zero !== want.zero)
                  report_mismatch("is_zero", rsp_is_zero, want.zero);
            end
         end
         quiet_cycles <= ((start && !busy) || rsp_valid) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL vector3_normalize");
            $finish;
         end
      end
   end

   initial begin
      vector_t v;
      logic signed [31:0] edges[6];
      edges = '{32'sh0, 32'sh1, -32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
      // Directed: zero vector, single axes, extreme and most negative values.
      pending_vectors.push_back('{x: 0, y: 0, z: 0});
      for (int i = 1; i < 6; i++) begin
         pending_vectors.push_back('{x: edges[i], y: 0, z: 0});
         pending_vectors.push_back('{x: 0, y: edges[i], z: 0});
         pending_vectors.push_back('{x: 0, y: 0, z: edges[i]});
      end
      pending_vectors.push_back('{x: 32'sh8000_0000, y: 32'sh8000_0000, z: 32'sh8000_0000});
      pending_vectors.push_back('{x: 32'sh7FFF_FFFF, y: 32'sh7FFF_FFFF, z: 32'sh7FFF_FFFF});
      pending_vectors.push_back('{x: 1, y: -1, z: 1});
      pending_vectors.push_back('{x: 32'sh5555_5555, y: 32'shAAAA_AAAA, z: 32'sh0F0F_0F0F});
      for (int n = 0; n < 500; n++) begin
         v.x = random_component();
         v.y = random_component();
         v.z = random_component();
         pending_vectors.push_back(v);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // A stretch with no idling early on, then random gaps.
      calm_stretch <= 1'b1;
      repeat (150) @(posedge clock);
      calm_stretch <= 1'b0;
      wait (pending_vectors.size() == 0);
      @(posedge clock);
      wait (expected_units.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS vector3_normalize");
      end else begin
         $display("FAIL vector3_normalize");
      end
      $finish;
   end

endmodule
